### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HBP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hbp_pkg.sv
`timescale 1ns / 1ps

package hbp_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN     = 32;

    localparam int WORD_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
    localparam int BUF_W     = WORD_W + BYTE_W;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // code is left aligned: first bit to send sits in bit WORD_W-1
    typedef struct packed {
        logic              flush;
        logic [WORD_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hbp_item_t;

endpackage

### rtl/hbp_front.sv
`timescale 1ns / 1ps

module hbp_front #(
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          opcode,
    input  logic [7:0]          symbol,
    input  logic [31:0]         code_word,
    input  logic [5:0]          code_length,
    input  logic                q_full,
    output logic                q_push,
    output hbp_pkg::hbp_item_t  q_item
);
    import hbp_pkg::*;

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    logic [WORD_W+LEN_W-1:0] table_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] entry_vld_reg;

    logic              stage_vld_reg;
    logic              stage_vld_next;
    logic              stage_flush_reg;
    logic              stage_hit_reg;
    logic              rd_vld_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    logic              accept;
    logic              in_range;
    logic              want_push;
    logic              stage_move;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  load_len;
    logic [LEN_W-1:0]  stage_len;
    logic [LEN_W-1:0]  shift_amt;

    assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
    assign idx      = symbol[IDX_W-1:0];
    assign load_len = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;

    // unloaded or out-of-range symbols encode to nothing and are dropped here
    assign stage_len  = (stage_hit_reg && rd_vld_reg) ? rd_len_reg : '0;
    assign want_push  = stage_flush_reg || (stage_len != '0);
    assign q_push     = stage_vld_reg && want_push && !q_full;
    assign stage_move = stage_vld_reg && (!want_push || !q_full);
    assign item_ready = !stage_vld_reg || stage_move;
    assign accept     = item_valid && item_ready;

    assign shift_amt    = LEN_W'(WORD_W) - stage_len;
    assign q_item.flush = stage_flush_reg;
    assign q_item.len   = stage_flush_reg ? '0 : stage_len;
    assign q_item.code  = stage_flush_reg ? '0 : (rd_word_reg << shift_amt);

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (accept)
        begin
            stage_vld_next = (opcode == OP_ENCODE) || (opcode == OP_FLUSH);
        end
        else if (stage_move)
        begin
            stage_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            entry_vld_reg <= '0;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            if (accept && (opcode == OP_LOAD) && in_range)
            begin
                entry_vld_reg[idx] <= 1'b1;
            end
        end
    end

    // code table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_LOAD) && in_range)
        begin
            table_mem[idx] <= {code_word, load_len};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_flush_reg           <= (opcode == OP_FLUSH);
            stage_hit_reg             <= in_range;
            rd_vld_reg                <= entry_vld_reg[idx];
            {rd_word_reg, rd_len_reg} <= table_mem[idx];
        end
    end

endmodule

### rtl/hbp_queue.sv
`timescale 1ns / 1ps

module hbp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hbp_pkg::hbp_item_t  item_in,
    input  logic                pop,
    output hbp_pkg::hbp_item_t  item_out,
    output logic                full,
    output logic                empty
);
    import hbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    hbp_item_t        entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign item_out = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/hbp_back.sv
`timescale 1ns / 1ps

module hbp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  hbp_pkg::hbp_item_t  q_item,
    output logic                q_pop,
    output logic                byte_valid,
    input  logic                byte_ready,
    output logic [7:0]          packed_byte,
    output logic                last_of_run
);
    import hbp_pkg::*;

    // buf_reg holds bits_reg bits left aligned, zeros below
    logic [BUF_W-1:0]  buf_reg;
    logic [BUF_W-1:0]  buf_next;
    logic [LEN_W-1:0]  bits_reg;
    logic [LEN_W-1:0]  bits_next;
    logic              out_vld_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              slot_free;
    logic              have_byte;
    logic              produce;
    logic              last_next;

    assign slot_free = !out_vld_reg || byte_ready;
    assign have_byte = (bits_reg >= LEN_W'(BYTE_W));

    always_comb
    begin
        produce   = 1'b0;
        q_pop     = 1'b0;
        last_next = 1'b0;
        buf_next  = buf_reg;
        bits_next = bits_reg;
        if (have_byte)
        begin
            // drain the current run before taking the next beat
            if (slot_free)
            begin
                produce   = 1'b1;
                last_next = (bits_reg < LEN_W'(2 * BYTE_W));
                buf_next  = buf_reg << BYTE_W;
                bits_next = bits_reg - LEN_W'(BYTE_W);
            end
        end
        else if (!q_empty)
        begin
            if (q_item.flush)
            begin
                if (bits_reg == '0)
                begin
                    q_pop = 1'b1;
                end
                else if (slot_free)
                begin
                    q_pop     = 1'b1;
                    produce   = 1'b1;
                    last_next = 1'b1;
                    buf_next  = '0;
                    bits_next = '0;
                end
            end
            else
            begin
                q_pop     = 1'b1;
                buf_next  = buf_reg | ({q_item.code, {BYTE_W{1'b0}}} >> bits_reg);
                bits_next = bits_reg + q_item.len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            bits_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            bits_reg <= bits_next;
            if (slot_free)
            begin
                out_vld_reg <= produce;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_byte_reg <= buf_reg[BUF_W-1 -: BYTE_W];
            out_last_reg <= last_next;
        end
    end

    assign byte_valid  = out_vld_reg;
    assign packed_byte = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

### rtl/huffman_bit_packer.sv
`timescale 1ns / 1ps
// Front takes one beat per cycle unless the queue is full; a load yields nothing.
// Encode: the code is merged into the packer buffer, then sent out byte by byte;
// the packer sets the rate and sends out its bytes before it takes the next beat.
// Path: front stage, queue, packer buffer, output register; a flush skips the buffer.
// rst_n (async, active low) clears code table valid bits, front stage, queue and packer.
module huffman_bit_packer #(
    parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_word,
    input  logic [5:0]  code_length,
    output logic        byte_valid,
    input  logic        byte_ready,
    output logic [7:0]  packed_byte,
    output logic        last_of_run
);
    import hbp_pkg::*;

    hbp_item_t push_item;
    hbp_item_t head_item;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    hbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .opcode      (opcode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    hbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (push_item),
        .pop      (q_pop),
        .item_out (head_item),
        .full     (q_full),
        .empty    (q_empty)
    );

    hbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .packed_byte (packed_byte),
        .last_of_run (last_of_run)
    );

endmodule

### rtl/hbp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_ready,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic [7:0]  packed_byte,
    input logic        last_of_run
);

    logic       byte_stall;
    logic       byte_run;
    logic [8:0] byte_beat;

    assign byte_stall = byte_valid && !byte_ready;
    assign byte_run   = byte_valid && byte_ready && !last_of_run;
    assign byte_beat  = {packed_byte, last_of_run};

    `HBP_ASSERT_CLK(a_byte_hold, clk, rst_n, byte_stall |=> byte_valid, "byte beat dropped")
    `HBP_ASSERT_CLK(a_byte_stable, clk, rst_n, byte_stall |=> $stable(byte_beat), "beat moved in stall")
    // a run is not over until its last byte: the next byte is already waiting
    `HBP_ASSERT_CLK(a_run_continues, clk, rst_n, byte_run |=> byte_valid, "gap inside a byte run")
    `HBP_ASSERT_ALWAYS(a_reset_idle, clk, !$past(rst_n) |-> !byte_valid && item_ready, "busy after reset")

endmodule

bind huffman_bit_packer hbp_checker u_checker (.*);

### tb/sv/huffman_bit_packer_tb.sv
`timescale 1ns / 1ps

module huffman_bit_packer_tb;

    import hbp_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, must do nothing
    localparam int LIMIT_CYCLES    = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 60;      // output beats before the long hold
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_ITEMS    = 420;
    localparam int QUIET_ITEMS     = 60;
    localparam int POOL_TOP        = 15;      // symbols 0..15 see most traffic

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    class byte_stream_model;
        logic [WORD_W-1:0] code_words[256];
        int                code_lens[256];
        logic [6:0]        acc_bits;
        int                acc_count;
        out_byte_t         pending_bytes[$];
        int                errors;
        int                n_load, n_encode, n_flush, n_none, n_bytes;

        function new();
            int k;
            for (k = 0; k < 256; k++)
            begin
                code_words[k] = '0;
                code_lens[k]  = 0;
            end
            acc_bits  = '0;
            acc_count = 0;
            errors    = 0;
            n_load    = 0;
            n_encode  = 0;
            n_flush   = 0;
            n_none    = 0;
            n_bytes   = 0;
        endfunction

        // Update the packer state for one accepted input beat and queue its bytes.
        function void note_item(logic [1:0] op, logic [7:0] sym, logic [31:0] word,
                                logic [5:0] len);
            int        n;
            int        i;
            int        first;
            logic [7:0] work;
            out_byte_t ob;
            first = pending_bytes.size();
            case (op)
                OP_LOAD:
                begin
                    n_load++;
                    n = (len > LEN_LIMIT) ? LEN_LIMIT : int'(len);
                    if (n < WORD_W)
                        word &= (32'h1 << n) - 32'h1;
                    code_words[sym] = word;
                    code_lens[sym]  = n;
                end
                OP_ENCODE:
                begin
                    n_encode++;
                    work = {1'b0, acc_bits};
                    for (i = code_lens[sym]; i > 0; i--)
                    begin
                        work = {work[6:0], code_words[sym][i-1]};
                        acc_count++;
                        if (acc_count == BYTE_W)
                        begin
                            ob.data = work;
                            ob.last = 1'b0;
                            pending_bytes.push_back(ob);
                            work      = '0;
                            acc_count = 0;
                        end
                    end
                    acc_bits = work[6:0];
                    if (pending_bytes.size() > first)
                        pending_bytes[pending_bytes.size()-1].last = 1'b1;
                end
                OP_FLUSH:
                begin
                    n_flush++;
                    if (acc_count > 0)
                    begin
                        ob.data = {1'b0, acc_bits} << (BYTE_W - acc_count);
                        ob.last = 1'b1;
                        pending_bytes.push_back(ob);
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
                default:
                    n_none++;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            out_byte_t want;
            n_bytes++;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %02h last_of_run %b", $time, data, last);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data)
            begin
                $display("%0t: packed_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  packed_byte;
    logic        last_of_run;

    byte_stream_model sb = new();
    bit  quiet_tail = 1'b0;
    bit  tx_bursty  = 1'b1;
    bit  rx_bursty  = 1'b1;
    int  cycles     = 0;

    huffman_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .opcode      (opcode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .packed_byte (packed_byte),
        .last_of_run (last_of_run)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d bytes outstanding", $time, sb.outstanding());
            $display("huffman_bit_packer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
            sb.check_byte(packed_byte, last_of_run);
    end

    // Receiver: short random stalls, plus one long hold so the block backs up.
    initial
    begin
        int rx_beats;
        int stall_left;
        int hold_left;
        bit held;
        rx_beats   = 0;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        byte_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (byte_valid && byte_ready)
                rx_beats++;
            if (rx_beats % 50 == 0)
                rx_bursty = $urandom_range(0, 1);
            if (hold_left > 0)
            begin
                hold_left--;
                byte_ready <= 1'b0;
            end
            else if (!held && rx_beats >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                byte_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                byte_ready <= 1'b0;
            end
            else if (!quiet_tail && rx_bursty && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                byte_ready <= 1'b0;
            end
            else
                byte_ready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [31:0] word,
                             logic [5:0] len);
        int gap;
        item_valid  <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        code_word   <= word;
        code_length <= len;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(op, sym, word, len);
        if (!quiet_tail && tx_bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_item();
        int         pick;
        logic [7:0] sym;
        logic [5:0] len;
        pick = $urandom_range(0, 99);
        sym  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, POOL_TOP))
                                          : 8'($urandom_range(0, 255));
        if (pick < 15)
        begin
            case ($urandom_range(0, 19))
                0:       len = 6'($urandom_range(33, 63));
                1, 2, 3: len = 6'($urandom_range(13, 32));
                4:       len = '0;
                default: len = 6'($urandom_range(1, 12));
            endcase
            send_item(OP_LOAD, sym, $urandom, len);
        end
        else if (pick < 85)
            send_item(OP_ENCODE, sym, $urandom, 6'($urandom));
        else if (pick < 95)
            send_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        else
            send_item(OP_NONE, 8'($urandom), $urandom, 6'($urandom));
    endtask

    initial
    begin
        int k;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        opcode      <= OP_LOAD;
        symbol      <= '0;
        code_word   <= '0;
        code_length <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, empty accumulator, unused opcode, a zero-length code, then first loads
        send_item(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(OP_NONE, 8'd255, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
        send_item(OP_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(OP_LOAD, 8'd1, 32'h0000_0001, 6'd1);
        send_item(OP_LOAD, 8'd2, 32'h0000_00A5, 6'd8);
        send_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        // over-long lengths saturate; stray high code bits are dropped
        send_item(OP_LOAD, 8'd3, 32'hDEAD_BEEF, 6'd63);
        send_item(OP_LOAD, 8'd4, 32'hFFFF_FFFF, 6'd5);
        send_item(OP_LOAD, 8'd5, 32'h0000_0000, 6'd33);
        send_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd5, 32'h0, 6'd0);
        send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 0)
                tx_bursty = $urandom_range(0, 1);
            if (k == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            send_random_item();
        end
        send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
        item_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d encodes, %0d flushes, %0d unused opcodes;",
                 sb.n_load, sb.n_encode, sb.n_flush, sb.n_none);
        $display("checked %0d output beats with a long output hold and random stalls.",
                 sb.n_bytes);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("huffman_bit_packer_tb OK");
        else
            $display("huffman_bit_packer_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/hbp_pkg.sv
rtl/hbp_front.sv
rtl/hbp_queue.sv
rtl/hbp_back.sv
rtl/huffman_bit_packer.sv
rtl/hbp_checker.sv
tb/sv/huffman_bit_packer_tb.sv
